// File: src/rcpc_pkg.sv
// Shared types and constants for the RC channel pulse conditioner.
package rcpc_pkg;

  localparam int PULSE_W   = 12;
  localparam int DZ_W      = 6;
  localparam int ADDR_W    = 3;
  localparam int DIFF_W    = PULSE_W + 2;             // signed working width
  localparam int PROD_W    = 2 * PULSE_W + 1;         // |out span| * (rc - in_min)
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [PULSE_W-1:0] MIDDLE_VALUE   = 12'd1500;
  localparam logic [PULSE_W-1:0] FAILSAFE_FLOOR = 12'd800;
  localparam logic [PULSE_W-1:0] DZ_LOW_BASE    = 12'd1450;
  localparam logic [PULSE_W-1:0] DZ_HIGH_BASE   = 12'd1550;
  localparam logic [PULSE_W-1:0] SAT_MAX        = 12'd4095;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_IN_MIN    = 3'd0;
  localparam logic [ADDR_W-1:0] REG_IN_MAX    = 3'd1;
  localparam logic [ADDR_W-1:0] REG_OUT_MIN   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_OUT_MAX   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_DEAD_ZONE = 3'd4;
  localparam logic [ADDR_W-1:0] REG_REVERSE   = 3'd5;
  localparam logic [ADDR_W-1:0] REG_FS_EN     = 3'd6;
  localparam logic [ADDR_W-1:0] REG_FS_THR    = 3'd7;

  typedef struct packed {
    logic [PULSE_W-1:0] in_min;
    logic [PULSE_W-1:0] in_max;
    logic [PULSE_W-1:0] out_min;
    logic [PULSE_W-1:0] out_max;
    logic [DZ_W-1:0]    dead_zone;
    logic               reverse;
    logic               fs_enable;
    logic [PULSE_W-1:0] fs_threshold;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [PULSE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_stat_t;

endpackage

// File: src/rcpc_cfg_regs.sv
// Configuration register file of the pulse conditioner.
module rcpc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rcpc_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [rcpc_pkg::PULSE_W-1:0] cfg_wdata_i,
  output rcpc_pkg::cfg_t              cfg_o
);

  rcpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rcpc_pkg::REG_IN_MIN:    cfg_d.in_min       = cfg_wdata_i;
        rcpc_pkg::REG_IN_MAX:    cfg_d.in_max       = cfg_wdata_i;
        rcpc_pkg::REG_OUT_MIN:   cfg_d.out_min      = cfg_wdata_i;
        rcpc_pkg::REG_OUT_MAX:   cfg_d.out_max      = cfg_wdata_i;
        rcpc_pkg::REG_DEAD_ZONE: cfg_d.dead_zone    = cfg_wdata_i[rcpc_pkg::DZ_W-1:0];
        rcpc_pkg::REG_REVERSE:   cfg_d.reverse      = cfg_wdata_i[0];
        rcpc_pkg::REG_FS_EN:     cfg_d.fs_enable    = cfg_wdata_i[0];
        rcpc_pkg::REG_FS_THR:    cfg_d.fs_threshold = cfg_wdata_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_min       <= 12'd1000;
      cfg_q.in_max       <= 12'd2000;
      cfg_q.out_min      <= 12'd1000;
      cfg_q.out_max      <= 12'd2000;
      cfg_q.dead_zone    <= '0;
      cfg_q.reverse      <= 1'b0;
      cfg_q.fs_enable    <= 1'b0;
      cfg_q.fs_threshold <= 12'd975;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/rcpc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module rcpc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcpc_pkg::div_req_t   req_i,
  output rcpc_pkg::div_stat_t  stat_o
);

  logic [rcpc_pkg::PROD_W-1:0]  quo_q, quo_d;
  logic [rcpc_pkg::PULSE_W-1:0] rem_q, rem_d;
  logic [rcpc_pkg::PULSE_W-1:0] dvs_q, dvs_d;
  logic [rcpc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [rcpc_pkg::PULSE_W:0]   trial;
  logic [rcpc_pkg::PULSE_W:0]   trial_sub;
  logic                         fits;

  // shift in next dividend bit, try the subtract
  assign trial     = {rem_q, quo_q[rcpc_pkg::PROD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = rcpc_pkg::CNT_W'(rcpc_pkg::DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[rcpc_pkg::PULSE_W-1:0] : trial[rcpc_pkg::PULSE_W-1:0];
      quo_d = {quo_q[rcpc_pkg::PROD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rcpc_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.quotient = quo_q;

endmodule

// File: src/rc_channel_pulse_conditioner_top.sv
// Top level of the RC channel pulse conditioner: sequencer, datapath and output register.
// Usage:
//   Input channel (in_valid_i / in_ready_o / pulse_i) takes one raw pulse
//   width per item. Output channel (out_valid_o / out_ready_i) returns one
//   item per input: value_o, the conditioned value, and failsafe_o, the
//   fail-safe flag after this update.
//   Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i at
//   the clock edge, no wait. Write only while the block is idle.
// Timing:
//   An item that is rescaled runs through the single 25-step restoring
//   divider: states CLAMP, DIFF, MUL, DIV (until the divider is done), FIN.
//   Items resolved without division (dead zone snap, at or below in_min,
//   degenerate input range) skip MUL and DIV: CLAMP, DIFF, FIN. When the
//   output does not stall, the divider iteration sets the rate. in_ready_o is high only while idle.
// Reset: filter state and fail-safe flag clear to zero, registers take
//   their defaults, no output item is pending.
// Stall:
//   The result sits in an output register; the sequencer goes back to idle
//   and takes the next item while it waits. A second result waits in the
//   final state until the output register frees up.
module rc_channel_pulse_conditioner_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rcpc_pkg::PULSE_W-1:0] pulse_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rcpc_pkg::PULSE_W-1:0] value_o,
  output logic                         failsafe_o,
  input  logic                         cfg_we_i,
  input  logic [rcpc_pkg::ADDR_W-1:0]  cfg_addr_i,
  input  logic [rcpc_pkg::PULSE_W-1:0] cfg_wdata_i
);

  localparam int W  = rcpc_pkg::PULSE_W;
  localparam int DW = rcpc_pkg::DIFF_W;
  localparam int SW = rcpc_pkg::PROD_W + 2;   // out_min + signed quotient

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLAMP = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  rcpc_pkg::cfg_t      cfg;
  rcpc_pkg::div_req_t  div_req;
  rcpc_pkg::div_stat_t div_stat;

  logic [2:0]          state_q, state_d;
  logic [W-1:0]        filt_q, filt_d;
  logic                flag_q, flag_d;
  logic signed [DW-1:0] rc_q, rc_d;
  logic                snap_q, snap_d;
  logic [W:0]          dmag_q, dmag_d;     // rc - in_min, positive on the divide path
  logic [W-1:0]        den_q, den_d;
  logic [W-1:0]        omag_q, omag_d;     // |out_max - out_min|
  logic                neg_q, neg_d;
  logic [W-1:0]        res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [W-1:0]        out_val_q, out_val_d;
  logic                out_fs_q, out_fs_d;

  logic                in_acc;
  logic                out_free;
  logic [W:0]          pulse_sum;
  logic [W-1:0]        filt_new;
  logic [W-1:0]        lo_bound;
  logic [W-1:0]        rc_cl;
  logic signed [DW-1:0] rc_rev;
  logic [W-1:0]        dz_lo, dz_hi;
  logic signed [DW-1:0] diff;
  logic signed [W:0]   den_s;
  logic signed [W:0]   odiff;
  logic [W:0]          odiff_neg;
  logic [W-1:0]        rc_sat;
  logic [rcpc_pkg::PROD_W-1:0] prod;
  logic signed [SW-1:0] q_ext;
  logic signed [SW-1:0] scaled;
  logic [W-1:0]        scaled_sat;

  rcpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  rcpc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .stat_o(div_stat)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // averaging filter, 13-bit sum halved
  assign pulse_sum = {1'b0, pulse_i} + {1'b0, filt_q};
  assign filt_new  = pulse_sum[W:1];

  // clamp: when the bounds cross, a value below the lower bound takes it, any other takes in_max
  assign lo_bound = flag_q ? rcpc_pkg::FAILSAFE_FLOOR : cfg.in_min;
  always_comb begin
    priority if (filt_q < lo_bound) rc_cl = lo_bound;
    else if (filt_q > cfg.in_max)   rc_cl = cfg.in_max;
    else                            rc_cl = filt_q;
  end
  // mirror: in_max + in_min - rc, may go negative or past 4095
  assign rc_rev = $signed({2'b00, cfg.in_max}) + $signed({2'b00, cfg.in_min})
                - $signed({2'b00, rc_cl});

  // snap window tests the filtered pulse, not the clamped one
  assign dz_lo = rcpc_pkg::DZ_LOW_BASE + {{(W-rcpc_pkg::DZ_W){1'b0}}, cfg.dead_zone};
  assign dz_hi = rcpc_pkg::DZ_HIGH_BASE - {{(W-rcpc_pkg::DZ_W){1'b0}}, cfg.dead_zone};

  assign diff      = rc_q - $signed({2'b00, cfg.in_min});
  assign den_s     = $signed({1'b0, cfg.in_max}) - $signed({1'b0, cfg.in_min});
  assign odiff     = $signed({1'b0, cfg.out_max}) - $signed({1'b0, cfg.out_min});
  assign odiff_neg = -odiff;

  always_comb begin
    priority if (rc_q[DW-1]) rc_sat = '0;
    else if (rc_q[DW-2])     rc_sat = rcpc_pkg::SAT_MAX;
    else                     rc_sat = rc_q[W-1:0];
  end

  assign prod = omag_q * dmag_q;

  assign div_req.start    = (state_q == S_MUL);
  assign div_req.dividend = prod;
  assign div_req.divisor  = den_q;

  // out_min +/- quotient, truncation toward zero via sign-magnitude
  assign q_ext  = $signed({2'b00, div_stat.quotient});
  assign scaled = $signed({{(SW-W){1'b0}}, cfg.out_min}) + (neg_q ? -q_ext : q_ext);
  always_comb begin
    priority if (scaled[SW-1])  scaled_sat = '0;
    else if (|scaled[SW-2:W])   scaled_sat = rcpc_pkg::SAT_MAX;
    else                        scaled_sat = scaled[W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    filt_d      = filt_q;
    flag_d      = flag_q;
    rc_d        = rc_q;
    snap_d      = snap_q;
    dmag_d      = dmag_q;
    den_d       = den_q;
    omag_d      = omag_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_fs_d    = out_fs_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          filt_d = filt_new;
          priority if (!cfg.fs_enable)          flag_d = 1'b0;
          else if (filt_new > cfg.fs_threshold) flag_d = 1'b0;
          else if (filt_new < cfg.fs_threshold) flag_d = 1'b1;
          else                                  flag_d = flag_q;
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        rc_d    = cfg.reverse ? rc_rev : $signed({2'b00, rc_cl});
        snap_d  = (cfg.dead_zone != '0) && (filt_q >= dz_lo) && (filt_q <= dz_hi);
        state_d = S_DIFF;
      end
      S_DIFF: begin
        dmag_d  = diff[W:0];
        den_d   = den_s[W-1:0];
        neg_d   = odiff[W];
        omag_d  = odiff[W] ? odiff_neg[W-1:0] : odiff[W-1:0];
        state_d = S_FIN;
        priority if (snap_q) begin
          res_d = rcpc_pkg::MIDDLE_VALUE;
        end else if (!diff[DW-1] && (diff != '0)) begin
          if (!den_s[W] && (den_s != '0)) begin
            state_d = S_MUL;
          end else begin
            res_d = cfg.out_min;
          end
        end else begin
          res_d = flag_q ? rc_sat : cfg.out_min;
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_d   = scaled_sat;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_q;
          out_fs_d    = flag_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filt_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filt_q      <= filt_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rc_q      <= rc_d;
    snap_q    <= snap_d;
    dmag_q    <= dmag_d;
    den_q     <= den_d;
    omag_q    <= omag_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    out_val_q <= out_val_d;
    out_fs_q  <= out_fs_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign failsafe_o  = out_fs_q;

endmodule

// File: src/rcpc_checker.sv
// Port-level checks for the pulse conditioner, bound to the top level.
module rcpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [rcpc_pkg::PULSE_W-1:0] pulse_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [rcpc_pkg::PULSE_W-1:0] value_o,
  input logic                         failsafe_o,
  input logic                         cfg_we_i,
  input logic [rcpc_pkg::ADDR_W-1:0]  cfg_addr_i,
  input logic [rcpc_pkg::PULSE_W-1:0] cfg_wdata_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(failsafe_o))
    else $error("output item changed while stalled");

  // an accepted item keeps the sequencer busy through its CLAMP and DIFF states
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after an accepted item");

  // posting a result returns the sequencer to idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("sequencer not idle after posting a result");

endmodule

bind rc_channel_pulse_conditioner_top rcpc_checker u_rcpc_checker (.*);
